@@ src/bhad_pkg.sv @@
// ----------------------------------------------------------------------------
// Button hold action dispatcher package
// Shared types, codes and default sizes for the dispatcher controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package bhad_pkg;

  localparam int NUM_RULES_DEF      = 8;
  localparam int NUM_KEYS_DEF       = 256;
  localparam int THRESHOLD_BITS_DEF = 16;

  localparam int ACTION_W     = 2;
  localparam int KEY_ID_W     = 8;
  localparam int RULE_INDEX_W = 3;
  localparam int CAUSE_W      = 2;
  localparam int CFG_INDEX_W  = 3;
  localparam int S_TDATA_W    = 16;
  localparam int M_TDATA_W    = 8;
  localparam int TIME_W       = 32;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TIMED   = 2'd2,
    KIND_FIRE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_PRESS   = 2'd0,
    CAUSE_TIMED   = 2'd1,
    CAUSE_RELEASE = 2'd2,
    CAUSE_FIRE    = 2'd3
  } cause_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PREP = 2'd1,
    ST_SCAN = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pend_any;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/button_hold_action_dispatcher_unit.sv @@
// ----------------------------------------------------------------------------
// Button hold action dispatcher
// A request is taken, prepared and scanned over all NUM_RULES rule words, one
// rule word per cycle; results then leave one per cycle unless m_tready holds
// the output. No new request is taken until all its results are issued.
// Reset clears the time counter, rule words, armed flags and the press time
// valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_hold_action_dispatcher_unit #(
  parameter int NUM_RULES      = bhad_pkg::NUM_RULES_DEF,
  parameter int NUM_KEYS       = bhad_pkg::NUM_KEYS_DEF,
  parameter int THRESHOLD_BITS = bhad_pkg::THRESHOLD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // action [1:0], key [9:2]
  input  logic [bhad_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // rule_index [2:0], cause [4:3]
  output logic [bhad_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bhad_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [THRESHOLD_BITS+10:0]        cfg_data
);

  bhad_pkg::ctrl_cmd_t  cmd;
  bhad_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  bhad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bhad_datapath #(
    .NUM_RULES      (NUM_RULES),
    .NUM_KEYS       (NUM_KEYS),
    .THRESHOLD_BITS (THRESHOLD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

@@ src/bhad_ctrl.sv @@
// ----------------------------------------------------------------------------
// Button hold action dispatcher controller
// Sequences one request through capture, preparation, the rule scan and
// the delivery of its results.
// ----------------------------------------------------------------------------
module bhad_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  bhad_pkg::dp_status_t status,
  output bhad_pkg::ctrl_cmd_t  cmd
);

  bhad_pkg::state_t state;
  bhad_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bhad_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = bhad_pkg::ST_PREP;
        end
      end
      bhad_pkg::ST_PREP: begin
        state_next = bhad_pkg::ST_SCAN;
      end
      bhad_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_next = bhad_pkg::ST_EMIT;
        end
      end
      bhad_pkg::ST_EMIT: begin
        if (!status.pend_any) begin
          state_next = bhad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bhad_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      bhad_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      bhad_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
      end
      bhad_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      bhad_pkg::ST_EMIT: begin
        cmd.emit = status.pend_any & status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/bhad_datapath.sv @@
// ----------------------------------------------------------------------------
// Button hold action dispatcher datapath
// Rule words, time counter, press time store, armed flags, the per-rule
// scan unit, the pending result set and the output register.
// ----------------------------------------------------------------------------
module bhad_datapath #(
  parameter int NUM_RULES      = bhad_pkg::NUM_RULES_DEF,
  parameter int NUM_KEYS       = bhad_pkg::NUM_KEYS_DEF,
  parameter int THRESHOLD_BITS = bhad_pkg::THRESHOLD_BITS_DEF,
  localparam int RULE_W        = THRESHOLD_BITS + 11,
  localparam int RIDX_W        = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1,
  localparam int KEY_W         = $clog2(NUM_KEYS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bhad_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bhad_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  input  logic [bhad_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [RULE_W-1:0]                 cfg_data,
  input  bhad_pkg::ctrl_cmd_t               cmd,
  output bhad_pkg::dp_status_t              status
);

  localparam int TW = bhad_pkg::TIME_W;

  logic [RULE_W-1:0]  rule_word [NUM_RULES];
  logic [NUM_RULES-1:0] armed;
  logic [TW-1:0]      fstart [NUM_RULES];
  logic [TW-1:0]      tick_count;
  logic [TW-1:0]      stamp_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] stamp_valid;
  logic [TW-1:0]      stamp_q;
  logic               stamp_vq;
  logic [TW-1:0]      hold;
  bhad_pkg::action_t  act;
  logic [KEY_W-1:0]   key_q;
  logic [RIDX_W-1:0]  ridx;
  logic [NUM_RULES-1:0] vec;
  logic               tfound;
  logic [RIDX_W-1:0]  tpick;
  logic [THRESHOLD_BITS-1:0] best;
  logic [bhad_pkg::RULE_INDEX_W-1:0] out_rule;
  bhad_pkg::cause_t   out_cause;

  bhad_pkg::action_t  in_action;
  logic [bhad_pkg::KEY_ID_W-1:0] in_key;
  logic               in_key_ok;
  logic [KEY_W-1:0]   in_addr;
  logic               stamp_we;
  logic               cfg_hit;
  logic [RIDX_W-1:0]  cfg_ridx;

  logic [RULE_W-1:0]  word;
  logic [bhad_pkg::KEY_ID_W-1:0] rkey;
  bhad_pkg::kind_t    rkind;
  logic [THRESHOLD_BITS-1:0] thr;
  logic               key_match;
  logic [TW-1:0]      elapsed;
  logic               fire_hit;
  logic               timed_hit;

  logic [RIDX_W-1:0]  low_idx;
  logic [NUM_RULES-1:0] low_bit;
  logic [NUM_RULES-1:0] vec_rest;
  bhad_pkg::cause_t   vec_cause;

  assign in_action = bhad_pkg::action_t'(s_tdata[bhad_pkg::ACTION_W-1:0]);
  assign in_key    = s_tdata[bhad_pkg::ACTION_W +: bhad_pkg::KEY_ID_W];
  assign in_key_ok = {1'b0, in_key} < (bhad_pkg::KEY_ID_W + 1)'(NUM_KEYS);
  assign in_addr   = in_key[KEY_W-1:0];
  assign stamp_we  = cmd.load && (in_action == bhad_pkg::ACT_PRESS) && in_key_ok;

  assign cfg_hit  = cfg_valid &&
                    ({1'b0, cfg_index} < (bhad_pkg::CFG_INDEX_W + 1)'(NUM_RULES));
  assign cfg_ridx = RIDX_W'(cfg_index);

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[in_addr] <= tick_count;
    end
    if (cmd.load) begin
      stamp_q <= stamp_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_valid <= '0;
    end else if (stamp_we) begin
      stamp_valid[in_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stamp_vq <= stamp_valid[in_addr];
      key_q    <= in_addr;
    end
    if (cmd.prep) begin
      hold <= tick_count - (stamp_vq ? stamp_q : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act        <= bhad_pkg::ACT_NONE;
      tick_count <= '0;
    end else if (cmd.load) begin
      if ((in_action == bhad_pkg::ACT_PRESS || in_action == bhad_pkg::ACT_RELEASE)
          && !in_key_ok) begin
        act <= bhad_pkg::ACT_NONE;
      end else begin
        act <= in_action;
      end
      if (in_action == bhad_pkg::ACT_TICK) begin
        tick_count <= tick_count + 1'b1;
      end
    end
  end

  assign word      = rule_word[ridx];
  assign rkey      = word[bhad_pkg::KEY_ID_W-1:0];
  assign rkind     = bhad_pkg::kind_t'(word[9:8]);
  assign thr       = word[10 +: THRESHOLD_BITS];
  assign key_match = word[10 + THRESHOLD_BITS] &&
                     (rkey == bhad_pkg::KEY_ID_W'(key_q));
  assign elapsed   = tick_count - fstart[ridx];
  assign fire_hit  = armed[ridx] && (elapsed >= TW'(thr));
  assign timed_hit = key_match && (rkind == bhad_pkg::KIND_TIMED) &&
                     (hold >= TW'(thr)) && (thr > best);

  always_comb begin
    low_idx = '0;
    low_bit = '0;
    for (int i = NUM_RULES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        low_idx = RIDX_W'(i);
        low_bit = NUM_RULES'(1) << i;
      end
    end
    vec_rest = vec & ~low_bit;
  end

  always_comb begin
    case (act)
      bhad_pkg::ACT_TICK:    vec_cause = bhad_pkg::CAUSE_FIRE;
      bhad_pkg::ACT_RELEASE: vec_cause = bhad_pkg::CAUSE_RELEASE;
      default:               vec_cause = bhad_pkg::CAUSE_PRESS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ridx   <= '0;
      vec    <= '0;
      tfound <= 1'b0;
      armed  <= '0;
      for (int i = 0; i < NUM_RULES; i++) begin
        rule_word[i] <= '0;
      end
    end else begin
      if (cmd.prep) begin
        ridx   <= '0;
        vec    <= '0;
        tfound <= 1'b0;
        best   <= '0;
      end
      if (cmd.scan) begin
        ridx <= ridx + 1'b1;
        case (act)
          bhad_pkg::ACT_TICK: begin
            if (fire_hit) begin
              armed[ridx] <= 1'b0;
              vec[ridx]   <= 1'b1;
            end
          end
          bhad_pkg::ACT_PRESS: begin
            if (key_match && rkind == bhad_pkg::KIND_PRESS) begin
              vec[ridx] <= 1'b1;
            end else if (key_match && rkind == bhad_pkg::KIND_FIRE) begin
              armed[ridx]  <= 1'b1;
              fstart[ridx] <= tick_count;
            end
          end
          bhad_pkg::ACT_RELEASE: begin
            if (timed_hit) begin
              best   <= thr;
              tpick  <= ridx;
              tfound <= 1'b1;
            end
            if (key_match && rkind == bhad_pkg::KIND_RELEASE) begin
              vec[ridx] <= 1'b1;
            end
            if (key_match && rkind == bhad_pkg::KIND_FIRE) begin
              armed[ridx] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.emit) begin
        if (tfound) begin
          tfound <= 1'b0;
        end else begin
          vec <= vec_rest;
        end
      end
      if (cfg_hit) begin
        rule_word[cfg_ridx] <= cfg_data;
        armed[cfg_ridx]     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (tfound) begin
        out_rule  <= bhad_pkg::RULE_INDEX_W'(tpick);
        out_cause <= bhad_pkg::CAUSE_TIMED;
        m_tlast   <= (vec == '0);
      end else begin
        out_rule  <= bhad_pkg::RULE_INDEX_W'(low_idx);
        out_cause <= vec_cause;
        m_tlast   <= (vec_rest == '0);
      end
    end
  end

  assign m_tdata = {3'b000, out_cause, out_rule};

  assign status.scan_last = (ridx == RIDX_W'(NUM_RULES - 1));
  assign status.pend_any  = tfound || (vec != '0);
  assign status.out_free  = !m_tvalid || m_tready;

endmodule
